FILE: hw/rtl/ffha_pkg.sv
package ffha_pkg;

  // field widths
  localparam int ADDR_W = 24;
  localparam int STAT_W = 3;

  // defaults and fixed sizes
  localparam int DEF_MAX_BLOCKS = 64;
  localparam int HEADER_BYTES   = 16;
  localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST = 24'd1048576;

  // command codes
  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 3'd0,
    ST_NULL    = 3'd1,
    ST_LIMIT   = 3'd2,
    ST_FULL    = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_GROW
  } state_t;

  // one row of the block table
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
    logic              free;
  } entry_t;

endpackage

FILE: hw/rtl/first_fit_heap_allocator_unit.sv
// channel   ports                                         handshake
// --------  --------------------------------------------  -------------------------------
// input     in_cmd, in_req_size, in_free_addr             start & !busy
// result    out_result_addr, out_status                   out_valid, one cycle, no stall
// config    cfg_heap_limit                                cfg_valid & cfg_ready
//
// a null request (zero size, null address) answers the cycle after it is accepted
// a table walk examines each entry with a memory read (S_RD), then a compare (S_CHK),
// and stops at the first hit or after the last of at most MAX_BLOCKS table entries
// growth of the heap runs in S_GROW after the walk; result strobes the cycle after
// reset clears the block count and heap top; table contents are not cleared
// busy stays high for the whole walk; results cannot be held off by the receiver
module first_fit_heap_allocator_unit #(
  parameter int MAX_BLOCKS = ffha_pkg::DEF_MAX_BLOCKS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_cmd,
  input  logic [ffha_pkg::ADDR_W-1:0] in_req_size,
  input  logic [ffha_pkg::ADDR_W-1:0] in_free_addr,
  output logic                        out_valid,
  output logic [ffha_pkg::ADDR_W-1:0] out_result_addr,
  output logic [ffha_pkg::STAT_W-1:0] out_status,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ffha_pkg::ADDR_W-1:0] cfg_heap_limit
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int AW    = ffha_pkg::ADDR_W;

  // block table
  ffha_pkg::entry_t mem [MAX_BLOCKS];
  ffha_pkg::entry_t rd_data_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  ffha_pkg::entry_t mem_wdata;

  // control and state registers
  ffha_pkg::state_t  state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [AW-1:0]     top_r, top_nxt;
  logic [AW-1:0]     limit_r;
  logic              cmd_r;
  logic [AW-1:0]     size_r;
  logic [AW-1:0]     addr_r;
  logic              out_valid_r;
  logic [AW-1:0]     res_addr_r;
  ffha_pkg::status_t res_status_r;

  // per-cycle decisions
  logic              accept;
  logic              in_null;
  logic              is_last;
  logic              alloc_hit;
  logic              free_hit;
  logic [AW+1:0]     new_top;
  logic [AW-1:0]     grow_start;
  logic              fin;
  logic [AW-1:0]     res_addr;
  ffha_pkg::status_t res_status;

  assign accept    = start && (state_r == ffha_pkg::S_IDLE);
  assign in_null   = (in_cmd == ffha_pkg::CMD_ALLOC) ? (in_req_size == '0)
                                                     : (in_free_addr == '0);
  assign is_last   = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign alloc_hit = (cmd_r == ffha_pkg::CMD_ALLOC) && rd_data_r.free
                     && (rd_data_r.size >= size_r);
  assign free_hit  = (cmd_r == ffha_pkg::CMD_FREE) && (rd_data_r.start == addr_r);
  assign new_top   = {2'b00, top_r} + (AW+2)'(ffha_pkg::HEADER_BYTES)
                     + {2'b00, size_r};
  assign grow_start = top_r + AW'(ffha_pkg::HEADER_BYTES);

  // datapath actions per state
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wdata  = rd_data_r;
    fin        = 1'b0;
    res_addr   = '0;
    res_status = ffha_pkg::ST_DONE;
    count_nxt  = count_r;
    top_nxt    = top_r;
    idx_nxt    = idx_r;
    case (state_r)
      ffha_pkg::S_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          if (in_null) begin
            fin        = 1'b1;
            res_status = ffha_pkg::ST_NULL;
          end else if ((in_cmd == ffha_pkg::CMD_FREE) && (count_r == '0)) begin
            fin        = 1'b1;
            res_status = ffha_pkg::ST_UNKNOWN;
          end
        end
      end
      ffha_pkg::S_RD: begin
      end
      ffha_pkg::S_CHK: begin
        if (alloc_hit) begin
          // reuse the whole block
          mem_we         = 1'b1;
          mem_wdata.free = 1'b0;
          fin            = 1'b1;
          res_addr       = rd_data_r.start;
        end else if (free_hit) begin
          fin = 1'b1;
          if (is_last) begin
            // pop the last block and lower the top
            count_nxt = count_r - CNT_W'(1);
            top_nxt   = addr_r - AW'(ffha_pkg::HEADER_BYTES);
          end else begin
            mem_we         = 1'b1;
            mem_wdata.free = 1'b1;
          end
        end else if (!is_last) begin
          idx_nxt = idx_r + IDX_W'(1);
        end else if (cmd_r == ffha_pkg::CMD_FREE) begin
          fin        = 1'b1;
          res_status = ffha_pkg::ST_UNKNOWN;
        end
      end
      ffha_pkg::S_GROW: begin
        fin = 1'b1;
        if (new_top > {2'b00, limit_r}) begin
          res_status = ffha_pkg::ST_LIMIT;
        end else if (count_r == CNT_W'(MAX_BLOCKS)) begin
          res_status = ffha_pkg::ST_FULL;
        end else begin
          // append a block at the heap top
          mem_we          = 1'b1;
          mem_waddr       = count_r[IDX_W-1:0];
          mem_wdata.start = grow_start;
          mem_wdata.size  = size_r;
          mem_wdata.free  = 1'b0;
          res_addr        = grow_start;
          count_nxt       = count_r + CNT_W'(1);
          top_nxt         = new_top[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffha_pkg::S_IDLE: begin
        if (accept && !fin) begin
          if ((in_cmd == ffha_pkg::CMD_ALLOC) && (count_r == '0)) begin
            state_nxt = ffha_pkg::S_GROW;
          end else begin
            state_nxt = ffha_pkg::S_RD;
          end
        end
      end
      ffha_pkg::S_RD: begin
        state_nxt = ffha_pkg::S_CHK;
      end
      ffha_pkg::S_CHK: begin
        if (alloc_hit || free_hit) begin
          state_nxt = ffha_pkg::S_IDLE;
        end else if (!is_last) begin
          state_nxt = ffha_pkg::S_RD;
        end else if (cmd_r == ffha_pkg::CMD_ALLOC) begin
          state_nxt = ffha_pkg::S_GROW;
        end else begin
          state_nxt = ffha_pkg::S_IDLE;
        end
      end
      ffha_pkg::S_GROW: begin
        state_nxt = ffha_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ffha_pkg::S_IDLE;
      end
    endcase
  end

  // table memory: writes land only at the end of an item, before the next read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[idx_r];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffha_pkg::S_IDLE;
      idx_r       <= '0;
      count_r     <= '0;
      top_r       <= '0;
      limit_r     <= ffha_pkg::HEAP_LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      top_r       <= top_nxt;
      out_valid_r <= fin;
      if (cfg_valid) begin
        limit_r <= cfg_heap_limit;
      end
    end
  end

  // captured item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_cmd;
      size_r <= in_req_size;
      addr_r <= in_free_addr;
    end
    if (fin) begin
      res_addr_r   <= res_addr;
      res_status_r <= res_status;
    end
  end

  assign busy            = (state_r != ffha_pkg::S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_result_addr = res_addr_r;
  assign out_status      = res_status_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_BLOCKS))
    else $error("block count beyond table depth");

  a_grow_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffha_pkg::S_GROW) |=> out_valid_r)
    else $error("growth step gave no result");

  a_write_place: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ffha_pkg::S_CHK || state_r == ffha_pkg::S_GROW))
    else $error("table written outside check or growth");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ffha_pkg::S_IDLE))
    else $error("result shown while still walking");

endmodule

FILE: bench/first_fit_heap_allocator_unit_tb.sv
`timescale 1ns / 1ps

module first_fit_heap_allocator_unit_tb;

  localparam int ADDR_W       = ffha_pkg::ADDR_W;
  localparam int STAT_W       = ffha_pkg::STAT_W;
  localparam int HEADER_BYTES = ffha_pkg::HEADER_BYTES;
  localparam int MAX_BLOCKS   = ffha_pkg::DEF_MAX_BLOCKS;
  localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST = ffha_pkg::HEAP_LIMIT_RST;

  // one heap operation as driven on the input ports
  typedef struct packed {
    ffha_pkg::cmd_t    op;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] addr;
  } heap_op_t;

  // one answer from the allocator
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    ffha_pkg::status_t status;
  } heap_answer_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_cmd = 1'b0;
  logic [ADDR_W-1:0] in_req_size = '0;
  logic [ADDR_W-1:0] in_free_addr = '0;
  logic              out_valid;
  logic [ADDR_W-1:0] out_result_addr;
  logic [STAT_W-1:0] out_status;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ADDR_W-1:0] cfg_heap_limit = '0;

  // stimulus and expectations
  heap_op_t     queued_heap_ops[$];
  heap_answer_t awaited_answers[$];
  logic         item_taken = 1'b0;
  int           send_idle_pct = 0;

  // shadow of the allocator state
  logic [ADDR_W-1:0] blk_start [MAX_BLOCKS];
  logic [ADDR_W-1:0] blk_size [MAX_BLOCKS];
  logic              blk_free [MAX_BLOCKS];
  int                blk_count = 0;
  logic [ADDR_W-1:0] heap_top_q = '0;
  logic [ADDR_W-1:0] heap_limit_q = HEAP_LIMIT_RST;

  // tallies
  int fail_count = 0;
  int items_accepted = 0;
  int answers_checked = 0;
  int limit_writes = 0;
  int status_tally [5] = '{default: 0};

  first_fit_heap_allocator_unit #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_req_size    (in_req_size),
    .in_free_addr   (in_free_addr),
    .out_valid      (out_valid),
    .out_result_addr(out_result_addr),
    .out_status     (out_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_heap_limit (cfg_heap_limit)
  );

  // clock
  always #2 clk = ~clk;

  // first-fit allocate or free against the shadow table
  task automatic compute_heap_answer(input heap_op_t req, output heap_answer_t ans);
    logic [ADDR_W+1:0] grown_top;
    int                hit;
    ans.addr = '0;
    ans.status = ffha_pkg::ST_DONE;
    hit = -1;
    if (req.op == ffha_pkg::CMD_ALLOC) begin
      if (req.size == '0) begin
        ans.status = ffha_pkg::ST_NULL;
      end else begin
        for (int i = 0; i < blk_count; i++) begin
          if (hit < 0 && blk_free[i] && blk_size[i] >= req.size) hit = i;
        end
        if (hit >= 0) begin
          // reuse whole, no split
          blk_free[hit] = 1'b0;
          ans.addr = blk_start[hit];
        end else begin
          grown_top = (ADDR_W+2)'(heap_top_q + HEADER_BYTES + req.size);
          if (grown_top > heap_limit_q) begin
            ans.status = ffha_pkg::ST_LIMIT;
          end else if (blk_count >= MAX_BLOCKS) begin
            ans.status = ffha_pkg::ST_FULL;
          end else begin
            blk_start[blk_count] = ADDR_W'(heap_top_q + HEADER_BYTES);
            blk_size[blk_count] = req.size;
            blk_free[blk_count] = 1'b0;
            ans.addr = blk_start[blk_count];
            blk_count++;
            heap_top_q = grown_top[ADDR_W-1:0];
          end
        end
      end
    end else begin
      if (req.addr == '0) begin
        ans.status = ffha_pkg::ST_NULL;
      end else begin
        for (int i = 0; i < blk_count; i++) begin
          if (hit < 0 && blk_start[i] == req.addr) hit = i;
        end
        if (hit < 0) begin
          ans.status = ffha_pkg::ST_UNKNOWN;
        end else if (hit == blk_count - 1) begin
          // last block pops and lowers the top
          heap_top_q = ADDR_W'(req.addr - HEADER_BYTES);
          blk_count--;
        end else begin
          blk_free[hit] = 1'b1;
        end
      end
    end
  endtask

  // driver: next item on the falling edge once the last one was taken
  always @(negedge clk) begin
    heap_op_t nxt;
    if (rst_n && (!start || item_taken)) begin
      if (queued_heap_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = queued_heap_ops.pop_front();
        start <= 1'b1;
        in_cmd <= nxt.op;
        in_req_size <= nxt.size;
        in_free_addr <= nxt.addr;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check answers, predict on accepted items, track limit writes
  always @(posedge clk) begin
    heap_op_t     req;
    heap_answer_t exp_ans;
    if (!rst_n) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= start && !busy;
      if (out_valid) begin
        if (awaited_answers.size() == 0) begin
          $error("answer with none awaited: result_addr %0d status %0d",
                 out_result_addr, out_status);
          fail_count++;
        end else begin
          exp_ans = awaited_answers.pop_front();
          answers_checked++;
          if (out_result_addr !== exp_ans.addr) begin
            $error("result_addr expected %0d actual %0d", exp_ans.addr, out_result_addr);
            fail_count++;
          end
          if (out_status !== exp_ans.status) begin
            $error("status expected %0d actual %0d", exp_ans.status, out_status);
            fail_count++;
          end
        end
        if (out_status <= ffha_pkg::ST_UNKNOWN) status_tally[out_status]++;
      end
      if (start && !busy) begin
        req.op = ffha_pkg::cmd_t'(in_cmd);
        req.size = in_req_size;
        req.addr = in_free_addr;
        compute_heap_answer(req, exp_ans);
        awaited_answers.push_back(exp_ans);
        items_accepted++;
      end
      if (cfg_valid && cfg_ready) begin
        heap_limit_q = cfg_heap_limit;
        limit_writes++;
      end
    end
  end

  // request sizes: mostly small, some zero, full range, single bits, exact fits
  function automatic logic [ADDR_W-1:0] pick_req_size();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 18) return ADDR_W'($urandom);
    if (r < 26) return 24'd1 << $urandom_range(ADDR_W-1);
    if (r < 36 && blk_count > 0) return blk_size[$urandom_range(blk_count-1)];
    return ADDR_W'($urandom_range(1, 256));
  endfunction

  // free addresses: mostly live blocks, some null, noise and stale starts
  function automatic logic [ADDR_W-1:0] pick_free_addr();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 18) return ADDR_W'($urandom);
    if (r < 26) return ADDR_W'(heap_top_q + HEADER_BYTES);
    if (blk_count == 0) return ADDR_W'($urandom_range(1, 4096));
    if (r < 50) return blk_start[blk_count-1];
    return blk_start[$urandom_range(blk_count-1)];
  endfunction

  task automatic queue_op(input ffha_pkg::cmd_t op, input logic [ADDR_W-1:0] size,
                          input logic [ADDR_W-1:0] addr);
    heap_op_t item;
    item.op = op;
    item.size = size;
    item.addr = addr;
    queued_heap_ops.push_back(item);
  endtask

  // random items, generated close to issue so frees follow the live table
  task automatic queue_random_ops(input int n, input int alloc_pct);
    for (int k = 0; k < n; k++) begin
      while (queued_heap_ops.size() >= 2) @(negedge clk);
      queue_op(($urandom_range(99) < alloc_pct) ? ffha_pkg::CMD_ALLOC : ffha_pkg::CMD_FREE,
               pick_req_size(), pick_free_addr());
    end
  endtask

  task automatic wait_until_idle();
    while (queued_heap_ops.size() != 0 || start || awaited_answers.size() != 0)
      @(negedge clk);
    while (busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_heap_limit(input logic [ADDR_W-1:0] value);
    int seen;
    seen = limit_writes;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_heap_limit <= value;
    while (limit_writes == seen) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // main sequence
  initial begin
    int settle;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: null cases, growth, reuse, pops, no merging, exact limit
    send_idle_pct = 0;
    queue_op(ffha_pkg::CMD_ALLOC, 24'd0, 24'd0);
    queue_op(ffha_pkg::CMD_FREE, 24'd0, 24'd0);
    queue_op(ffha_pkg::CMD_FREE, 24'hFFFFFF, 24'hFFFFFF);
    queue_op(ffha_pkg::CMD_ALLOC, 24'hFFFFFF, 24'd0);
    queue_op(ffha_pkg::CMD_ALLOC, 24'd1, 24'd0);
    queue_op(ffha_pkg::CMD_ALLOC, 24'd100, 24'd0);
    queue_op(ffha_pkg::CMD_ALLOC, 24'd50, 24'd0);
    queue_op(ffha_pkg::CMD_ALLOC, 24'd7, 24'd0);
    queue_op(ffha_pkg::CMD_FREE, 24'd0, 24'd33);
    queue_op(ffha_pkg::CMD_FREE, 24'd0, 24'd33);
    queue_op(ffha_pkg::CMD_ALLOC, 24'd200, 24'd0);
    queue_op(ffha_pkg::CMD_ALLOC, 24'd40, 24'd0);
    queue_op(ffha_pkg::CMD_FREE, 24'd0, 24'd149);
    queue_op(ffha_pkg::CMD_FREE, 24'd0, 24'd215);
    queue_op(ffha_pkg::CMD_FREE, 24'd0, 24'd238);
    queue_op(ffha_pkg::CMD_FREE, 24'd0, 24'd238);
    queue_op(ffha_pkg::CMD_FREE, 24'd0, 24'd215);
    queue_op(ffha_pkg::CMD_FREE, 24'd0, 24'd149);
    queue_op(ffha_pkg::CMD_FREE, 24'd0, 24'd34);
    queue_op(ffha_pkg::CMD_ALLOC, 24'd1048427, 24'hFFFFFF);
    queue_op(ffha_pkg::CMD_ALLOC, 24'd1, 24'd0);
    queue_op(ffha_pkg::CMD_FREE, 24'hFFFFFF, 24'd149);
    queue_op(ffha_pkg::CMD_FREE, 24'd0, 24'd33);
    queue_op(ffha_pkg::CMD_FREE, 24'd0, 24'd16);
    wait_until_idle();

    // fill the table past its depth at the top limit
    write_heap_limit(24'hFFFFFF);
    send_idle_pct = 64;
    for (int k = 0; k < MAX_BLOCKS + 2; k++)
      queue_op(ffha_pkg::CMD_ALLOC, ADDR_W'($urandom_range(1, 64)), ADDR_W'($urandom));
    repeat (4) queue_op(ffha_pkg::CMD_ALLOC, 24'hFFFFFF, 24'd0);
    wait_until_idle();

    // limit below the current top: only growth is blocked
    write_heap_limit(24'd0);
    send_idle_pct = 35;
    queue_random_ops(120, 50);
    wait_until_idle();

    write_heap_limit(24'd4096);
    send_idle_pct = 0;
    queue_random_ops(250, 55);
    wait_until_idle();

    write_heap_limit(HEAP_LIMIT_RST);
    send_idle_pct = 64;
    queue_random_ops(230, 50);
    wait_until_idle();

    write_heap_limit(24'hFFFFFF);
    send_idle_pct = 35;
    queue_random_ops(230, 60);

    // drain with a bound
    settle = 0;
    while ((queued_heap_ops.size() != 0 || start || awaited_answers.size() != 0)
           && settle < 4000) begin
      @(negedge clk);
      settle++;
    end
    repeat (2 * MAX_BLOCKS + 4) @(negedge clk);
    if (awaited_answers.size() != 0) begin
      $error("%0d answers never arrived", awaited_answers.size());
      fail_count++;
    end

    $display("%0d heap operations accepted, %0d answers checked, %0d limit settings",
             items_accepted, answers_checked, limit_writes);
    $display("answers: %0d done, %0d null, %0d over limit, %0d table full, %0d unknown",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4]);
    if (fail_count == 0) begin
      $display("first_fit_heap_allocator_unit: match");
    end else begin
      $display("first_fit_heap_allocator_unit: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("first_fit_heap_allocator_unit: mismatch");
    $finish;
  end

endmodule
